// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the checker files of the project
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion, masked while reset is high
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent assertion that also holds across reset
`define ASSERT_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/bqd_pkg.sv =====
// ----------------------------------------------------------------------------
// bqd_pkg
// Types, widths, register codes and scaling helper of the biquad filter
// ----------------------------------------------------------------------------
package bqd_pkg;

  localparam int DATA_WIDTH  = 16;
  localparam int ACC_WIDTH   = 32;
  localparam int COEF_WIDTH  = 16;
  localparam int SHIFT_WIDTH = 5;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  typedef logic signed [DATA_WIDTH-1:0]  sample_t;
  typedef logic signed [COEF_WIDTH-1:0]  coef_t;
  typedef logic signed [SHIFT_WIDTH-1:0] shift_t;
  typedef logic signed [ACC_WIDTH-1:0]   acc_t;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_B0        = 3'd0,
    REG_B1        = 3'd1,
    REG_B2        = 3'd2,
    REG_A1        = 3'd3,
    REG_A2        = 3'd4,
    REG_SHIFT_NUM = 3'd5,
    REG_SHIFT_DEN = 3'd6
  } cfg_reg_t;

  // filter settings handed to the datapath
  typedef struct packed {
    coef_t  b0;
    coef_t  b1;
    coef_t  b2;
    coef_t  a1;
    coef_t  a2;
    shift_t shift_num;
    shift_t shift_den;
  } bqd_coefs_t;

  // positive scale shifts right arithmetically, zero or negative shifts left
  function automatic acc_t scale_acc(acc_t acc, shift_t sh);
    logic [SHIFT_WIDTH-1:0] lsh;
    lsh = SHIFT_WIDTH'(-sh);
    if (sh > 0) begin
      return acc >>> unsigned'(sh);
    end else begin
      return acc << lsh;
    end
  endfunction

endpackage

// ===== design/bqd_sample_if.sv =====
// ----------------------------------------------------------------------------
// bqd_sample_if
// Input sample channel: valid/ready handshake with one signed sample
// ----------------------------------------------------------------------------
interface bqd_sample_if;
  logic             valid;
  logic             ready;
  bqd_pkg::sample_t sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

// ===== design/bqd_result_if.sv =====
// ----------------------------------------------------------------------------
// bqd_result_if
// Output sample channel: valid/ready handshake with one filtered sample
// ----------------------------------------------------------------------------
interface bqd_result_if;
  logic             valid;
  logic             ready;
  bqd_pkg::sample_t sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

// ===== design/bqd_cfg_if.sv =====
// ----------------------------------------------------------------------------
// bqd_cfg_if
// Register write channel: valid/ready handshake with index and write data
// ----------------------------------------------------------------------------
interface bqd_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [bqd_pkg::CFG_INDEX_W-1:0]    index;
  logic [bqd_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/bqd_datapath.sv =====
// ----------------------------------------------------------------------------
// bqd_datapath
// Direct form I arithmetic: five products, two scaled sums, output slice
// ----------------------------------------------------------------------------
module bqd_datapath (
  input  bqd_pkg::sample_t    x,
  input  bqd_pkg::sample_t    x_delay1,
  input  bqd_pkg::sample_t    x_delay2,
  input  bqd_pkg::sample_t    y_delay1,
  input  bqd_pkg::sample_t    y_delay2,
  input  bqd_pkg::bqd_coefs_t coefs,
  output bqd_pkg::sample_t    y
);
  import bqd_pkg::*;

  acc_t prod_b0, prod_b1, prod_b2, prod_a1, prod_a2;
  acc_t num_sum, den_sum, num_scaled, den_scaled, acc;

  // products, all wrapping at accumulator width
  assign prod_b0 = acc_t'(x)        * acc_t'(coefs.b0);
  assign prod_b1 = acc_t'(x_delay1) * acc_t'(coefs.b1);
  assign prod_b2 = acc_t'(x_delay2) * acc_t'(coefs.b2);
  assign prod_a1 = acc_t'(y_delay1) * acc_t'(coefs.a1);
  assign prod_a2 = acc_t'(y_delay2) * acc_t'(coefs.a2);

  // feedforward and feedback sums
  assign num_sum = prod_b0 + prod_b1 + prod_b2;
  assign den_sum = prod_a1 + prod_a2;

  assign num_scaled = scale_acc(num_sum, coefs.shift_num);
  assign den_scaled = scale_acc(den_sum, coefs.shift_den);

  // upper half of the accumulator, no saturation
  assign acc = num_scaled - den_scaled;
  assign y   = acc[DATA_WIDTH +: DATA_WIDTH];

endmodule

// ===== design/fixed_point_biquad_iir.sv =====
// ----------------------------------------------------------------------------
// fixed_point_biquad_iir
// Fixed-point direct form I biquad with programmable coefficients and scales
//
//   port     | role           | payload
//   ---------+----------------+------------------------------
//   sample   | input items    | sample_in (16 bit signed)
//   result   | output items   | sample_out (16 bit signed)
//   cfg      | register write | index (3 bit), data (16 bit)
//
// One item per cycle sustained while the result side is ready; an accepted item
// passes through the input register, then the result register.
// The whole filter step is one combinational pass from the input register to
// the result register, closing the feedback through the delay lines.
// Reset clears coefficients, scales and delay lines; cfg is always ready.
// A stalled result holds the input register full, then the input stalls.
// ----------------------------------------------------------------------------
module fixed_point_biquad_iir (
  input  logic           clk,
  input  logic           rst,
  bqd_sample_if.sink     sample,
  bqd_result_if.source   result,
  bqd_cfg_if.sink        cfg
);
  import bqd_pkg::*;

  bqd_coefs_t coefs;
  logic       stage_valid;
  sample_t    stage_x;
  logic       out_valid;
  sample_t    out_data;
  logic       advance;
  sample_t    x_delay1, x_delay2, y_delay1, y_delay2;
  sample_t    y_next;

  // register writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coefs <= '0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_B0:        coefs.b0        <= coef_t'(cfg.data);
        REG_B1:        coefs.b1        <= coef_t'(cfg.data);
        REG_B2:        coefs.b2        <= coef_t'(cfg.data);
        REG_A1:        coefs.a1        <= coef_t'(cfg.data);
        REG_A2:        coefs.a2        <= coef_t'(cfg.data);
        REG_SHIFT_NUM: coefs.shift_num <= shift_t'(cfg.data[SHIFT_WIDTH-1:0]);
        REG_SHIFT_DEN: coefs.shift_den <= shift_t'(cfg.data[SHIFT_WIDTH-1:0]);
        default: ;
      endcase
    end
  end

  // handshake: stage moves on whenever the result register is free or drained
  assign advance      = stage_valid && (!out_valid || result.ready);
  assign sample.ready = !stage_valid || !out_valid || result.ready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (sample.ready) begin
      stage_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      stage_x <= sample.sample_in;
    end
  end

  // filter arithmetic
  bqd_datapath u_datapath (
    .x        (stage_x),
    .x_delay1 (x_delay1),
    .x_delay2 (x_delay2),
    .y_delay1 (y_delay1),
    .y_delay2 (y_delay2),
    .coefs    (coefs),
    .y        (y_next)
  );

  // delay lines update as an item leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      x_delay1 <= '0;
      x_delay2 <= '0;
      y_delay1 <= '0;
      y_delay2 <= '0;
    end else if (advance) begin
      x_delay1 <= stage_x;
      x_delay2 <= x_delay1;
      y_delay1 <= y_next;
      y_delay2 <= y_delay1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= y_next;
    end
  end

  assign result.valid      = out_valid;
  assign result.sample_out = out_data;

endmodule

// ===== design/bqd_checker.sv =====
// ----------------------------------------------------------------------------
// bqd_checker
// Port-level checks of the biquad filter, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bqd_checker (
  input logic          clk,
  input logic          rst,
  bqd_sample_if.sink   sample,
  bqd_result_if.source result,
  bqd_cfg_if.sink      cfg
);

  // no result right after reset
  `ASSERT_CLK(a_idle_after_rst, clk, rst |=> !result.valid, "result valid after reset")

  // a stalled result keeps its value
  `ASSERT_CLK_RST(a_out_hold, clk, rst, (result.valid && !result.ready) |=> (result.valid && $stable(result.sample_out)), "stalled result changed")

  // a draining output never blocks the input
  `ASSERT_CLK_RST(a_in_ready, clk, rst, result.ready |-> sample.ready, "input stalled while output drains")

  // an accepted item reaches the result register when the output drains
  `ASSERT_CLK_RST(a_latency, clk, rst, (sample.valid && sample.ready ##1 result.ready) |=> result.valid, "item did not reach output")

  // register writes are never refused
  `ASSERT_CLK_RST(a_cfg_ready, clk, rst, cfg.valid |-> cfg.ready, "register write refused")

endmodule

bind fixed_point_biquad_iir bqd_checker u_bqd_checker (
  .clk    (clk),
  .rst    (rst),
  .sample (sample),
  .result (result),
  .cfg    (cfg)
);

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the fixed-point direct form I biquad: drives input
// samples and register writes over valid/ready channels, tracks the filter
// state in a scoreboard and compares every output sample as it is accepted.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bqd_pkg::*;

  localparam int     CLK_HALF    = 4;
  localparam int     RESET_LEN   = 9;
  localparam int     LONG_HOLD   = 48;
  localparam int     DRAIN_LIMIT = 500;
  localparam int     SETTLE      = 4;
  localparam int     PHASES      = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

  localparam sample_t SAMPLE_MIN = 16'sh8000;
  localparam sample_t SAMPLE_MAX = 16'sh7fff;
  localparam coef_t   COEF_MIN   = 16'sh8000;
  localparam coef_t   COEF_MAX   = 16'sh7fff;
  localparam shift_t  SHIFT_NONE = 5'sd0;
  localparam shift_t  SHIFT_R15  = 5'sd15;
  localparam shift_t  SHIFT_L15  = -5'sd15;
  localparam shift_t  SHIFT_L16  = 5'b10000;

  // running model of the filter and the outputs it still owes
  class filter_scoreboard;
    coef_t   b0, b1, b2, a1, a2;
    shift_t  num_shift, den_shift;
    sample_t x_d1, x_d2, y_d1, y_d2;
    sample_t owed_outputs[$];
    int      errors;
    int      accepted;
    int      compared;

    function new();
      b0 = '0; b1 = '0; b2 = '0; a1 = '0; a2 = '0;
      num_shift = '0; den_shift = '0;
      x_d1 = '0; x_d2 = '0; y_d1 = '0; y_d2 = '0;
      errors = 0; accepted = 0; compared = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_B0:        b0 = data;
        REG_B1:        b1 = data;
        REG_B2:        b2 = data;
        REG_A1:        a1 = data;
        REG_A2:        a2 = data;
        REG_SHIFT_NUM: num_shift = data[SHIFT_WIDTH-1:0];
        REG_SHIFT_DEN: den_shift = data[SHIFT_WIDTH-1:0];
        default: ;
      endcase
    endfunction

    // full-width signed product, wrapped to the accumulator
    function acc_t product(sample_t d, coef_t c);
      acc_t wd, wc;
      wd = acc_t'(d);
      wc = acc_t'(c);
      return wd * wc;
    endfunction

    // positive amount shifts right, zero or negative shifts left
    function acc_t rescale(acc_t v, shift_t sh);
      int amount;
      amount = int'(sh);
      if (amount > 0) return v >>> amount;
      return v << (-amount);
    endfunction

    // one filter step on an accepted sample
    function void take_input(sample_t x);
      acc_t    num, den, acc;
      sample_t y;
      num = product(x, b0) + product(x_d1, b1) + product(x_d2, b2);
      num = rescale(num, num_shift);
      den = product(y_d1, a1) + product(y_d2, a2);
      den = rescale(den, den_shift);
      acc = num - den;
      y = acc[ACC_WIDTH-1:DATA_WIDTH];
      x_d2 = x_d1;
      x_d1 = x;
      y_d2 = y_d1;
      y_d1 = y;
      owed_outputs.push_back(y);
      accepted++;
    endfunction

    function void check_output(sample_t y);
      sample_t want;
      if (owed_outputs.size() == 0) begin
        $error("sample_out arrived with nothing owed: actual %0d", y);
        errors++;
        return;
      end
      want = owed_outputs.pop_front();
      compared++;
      if (y !== want) begin
        $error("sample_out mismatch: expected %0d, actual %0d", want, y);
        errors++;
      end
    endfunction

    function int pending();
      return owed_outputs.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  bqd_sample_if smp ();
  bqd_result_if res ();
  bqd_cfg_if    cfg_ch ();

  fixed_point_biquad_iir dut (
    .clk    (clk),
    .rst    (rst),
    .sample (smp),
    .result (res),
    .cfg    (cfg_ch)
  );

  filter_scoreboard sb = new();

  bit source_idle_on = 1'b1;
  bit sink_idle_on   = 1'b1;
  bit long_hold_req  = 1'b0;
  int settings_used  = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  // watch all three channels
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) sb.write_reg(cfg_ch.index, cfg_ch.data);
      if (smp.valid && smp.ready) sb.take_input(smp.sample_in);
      if (res.valid && res.ready) sb.check_output(res.sample_out);
    end
  end

  // output side: random stalls plus one long hold-off on request
  initial begin : result_sink
    int gap;
    res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        res.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        res.ready <= 1'b1;
      end else if (sink_idle_on && $urandom_range(0, 4) == 0) begin
        gap = $urandom_range(1, 3);
        res.ready <= 1'b0;
        repeat (gap) @(posedge clk);
        res.ready <= 1'b1;
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  // one register write, valid left high for a following write
  task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx,
                         input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // load a full filter setting plus a write to the unused index; shift writes carry random upper bits
  task automatic set_filter(input bqd_coefs_t s);
    put_reg(REG_B0, s.b0);
    put_reg(REG_B1, s.b1);
    put_reg(REG_B2, s.b2);
    put_reg(REG_A1, s.a1);
    put_reg(REG_SHIFT_NUM, {(CFG_DATA_W-SHIFT_WIDTH)'($urandom), s.shift_num});
    put_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    put_reg(REG_A2, s.a2);
    put_reg(REG_SHIFT_DEN, {(CFG_DATA_W-SHIFT_WIDTH)'($urandom), s.shift_den});
    cfg_ch.valid <= 1'b0;
    settings_used++;
  endtask

  // offer one item, with an occasional idle burst ahead of it
  task automatic send_sample(input sample_t x);
    int gap;
    if (source_idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      smp.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    smp.valid     <= 1'b1;
    smp.sample_in <= x;
    do @(posedge clk); while (!smp.ready);
  endtask

  // stop offering and wait for every owed output
  task automatic drain();
    smp.valid <= 1'b0;
    @(posedge clk);
    for (int n = 0; n < DRAIN_LIMIT && sb.pending() != 0; n++) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic bqd_coefs_t random_setting();
    bqd_coefs_t r;
    r.b0 = coef_t'($urandom);
    r.b1 = coef_t'($urandom);
    r.b2 = coef_t'($urandom);
    r.a1 = coef_t'($urandom);
    r.a2 = coef_t'($urandom);
    r.shift_num = shift_t'($urandom);
    r.shift_den = shift_t'($urandom);
    return r;
  endfunction

  // mostly full-range samples, some extremes and small values
  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0:       return SAMPLE_MIN;
      1:       return SAMPLE_MAX;
      2, 3:    return sample_t'(int'($urandom_range(0, 127)) - 64);
      default: return sample_t'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    bqd_coefs_t s;
    sample_t    burst[$];
    int         n_items;

    rst           <= 1'b1;
    smp.valid     <= 1'b0;
    smp.sample_in <= '0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.index  <= '0;
    cfg_ch.data   <= '0;
    repeat (RESET_LEN) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // wrapping numerator sum with unscaled sums
    s = '{b0: COEF_MIN, b1: COEF_MIN, b2: COEF_MIN, a1: COEF_MAX, a2: COEF_MAX,
          shift_num: SHIFT_NONE, shift_den: SHIFT_NONE};
    set_filter(s);
    burst = '{SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MAX,
              SAMPLE_MAX, 16'sd0, -16'sd1, 16'sd1};
    foreach (burst[i]) send_sample(burst[i]);
    drain();

    // left scale by sixteen against the largest right scale
    s = '{b0: COEF_MAX, b1: COEF_MIN, b2: 16'sd1, a1: COEF_MIN, a2: COEF_MAX,
          shift_num: SHIFT_L16, shift_den: SHIFT_R15};
    set_filter(s);
    burst = '{16'sd1, -16'sd1, SAMPLE_MAX, SAMPLE_MIN, 16'sd0, 16'sh5555, 16'shaaaa};
    foreach (burst[i]) send_sample(burst[i]);
    drain();

    // largest right scale on the numerator, left by fifteen on feedback
    s = '{b0: 16'sd16384, b1: -16'sd1, b2: COEF_MIN, a1: 16'sd3, a2: -16'sd2,
          shift_num: SHIFT_R15, shift_den: SHIFT_L15};
    set_filter(s);
    burst = '{SAMPLE_MAX, SAMPLE_MIN, 16'sh00ff, 16'shff00, 16'sd0, 16'sd1, -16'sd1,
              SAMPLE_MIN};
    foreach (burst[i]) send_sample(burst[i]);
    drain();

    // random phases, each under its own setting
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: s = '{b0: COEF_MAX, b1: COEF_MAX, b2: COEF_MAX, a1: COEF_MAX, a2: COEF_MAX,
                 shift_num: SHIFT_R15, shift_den: SHIFT_R15};
        1: s = '{b0: COEF_MIN, b1: COEF_MIN, b2: COEF_MIN, a1: COEF_MIN, a2: COEF_MIN,
                 shift_num: SHIFT_L16, shift_den: SHIFT_L16};
        default: s = random_setting();
      endcase
      set_filter(s);
      // output held off while the input keeps pushing
      if (p == 3) begin
        source_idle_on = 1'b0;
        long_hold_req  = 1'b1;
      end
      // closing stretch runs flat out
      if (p == PHASES - 1) begin
        source_idle_on = 1'b0;
        sink_idle_on   = 1'b0;
      end
      n_items = (p == PHASES - 1) ? 150 : 125;
      for (int n = 0; n < n_items; n++) send_sample(pick_sample());
      drain();
      if (p == 3) source_idle_on = 1'b1;
    end

    if (sb.pending() != 0) begin
      $error("%0d expected sample_out values never arrived", sb.pending());
      sb.errors++;
    end
    $display("%0d samples filtered under %0d filter settings, %0d outputs compared",
             sb.accepted, settings_used, sb.compared);
    $display("covered wrapped sums, full scale range, unused register index, %0d-cycle stall",
             LONG_HOLD);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
